FILE: sv/psd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package psd_pkg;

   // Number format
   localparam int FRAC_BITS   = 16;
   localparam int COORD_WIDTH = 32;
   localparam int EXT_W       = COORD_WIDTH - 1;

   // Result widths: squared distance in Q32.32, distance in Q16.16
   localparam int DSQ_W  = 64;
   localparam int DIST_W = DSQ_W / 2;
   localparam int SQ_W   = DSQ_W / 2;

   // Projection datapath
   localparam int DIFF_W     = COORD_WIDTH + 1;
   localparam int DOT_PROD_W = COORD_WIDTH + DIFF_W;
   localparam int DOT_SUM_W  = DOT_PROD_W + 2;
   localparam int SHIFT_W    = DOT_SUM_W - FRAC_BITS;

   // Closest point datapath
   localparam int TD_W = 2 * COORD_WIDTH;
   localparam int C_W  = TD_W - FRAC_BITS + 1;
   localparam int DC_W = C_W + 1;

   // Square root pipeline
   localparam int SQRT_STEPS  = 2;
   localparam int SQRT_STAGES = DIST_W / SQRT_STEPS;
   localparam int REM_W       = DIST_W + 3;

   // Stage counts and total latency in register stages
   localparam int PROJ_STAGES  = 4;
   localparam int POINT_STAGES = 5;
   localparam int LATENCY      = PROJ_STAGES + POINT_STAGES + SQRT_STAGES;

   // Three components, index 0 is x
   typedef logic [2:0][COORD_WIDTH-1:0] vec_type;

   // Operands carried along the projection stages
   typedef struct packed {
      vec_type           point;
      vec_type           origin;
      vec_type           dir;
      logic [EXT_W-1:0]  ext;
   } carry_type;

   // Projection result handed to the closest point stages
   typedef struct packed {
      logic                    valid;
      logic [COORD_WIDTH-1:0]  seg_param;
      vec_type                 point;
      vec_type                 origin;
      vec_type                 dir;
   } proj_type;

   // Distance result handed to the square root stages
   typedef struct packed {
      logic                    valid;
      logic [COORD_WIDTH-1:0]  seg_param;
      vec_type                 closest;
      logic [DSQ_W-1:0]        dist_squared;
   } dist_type;

endpackage

`default_nettype wire

FILE: sv/psd_proj.sv
`timescale 1ns / 1ps
`default_nettype none

module psd_proj (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  psd_pkg::vec_type              in_point,
   input  psd_pkg::vec_type              in_origin,
   input  psd_pkg::vec_type              in_dir,
   input  logic [psd_pkg::EXT_W-1:0]     in_ext,
   output psd_pkg::proj_type             out
);
   import psd_pkg::*;

   logic                         s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   carry_type                    s1_carry_ff, s2_carry_ff, s3_carry_ff, s4_carry_ff;
   carry_type                    s1_carry_in;
   logic signed [DIFF_W-1:0]     s1_diff_in [3];
   logic signed [DIFF_W-1:0]     s1_diff_ff [3];
   logic signed [DOT_PROD_W-1:0] s2_prod_in [3];
   logic signed [DOT_PROD_W-1:0] s2_prod_ff [3];
   logic signed [DOT_SUM_W-1:0]  s3_sum_in;
   logic signed [DOT_SUM_W-1:0]  s3_sum_ff;
   logic signed [SHIFT_W-1:0]    s4_shift;
   logic signed [SHIFT_W-1:0]    s4_ext;
   logic signed [SHIFT_W-1:0]    s4_neg_ext;
   logic [COORD_WIDTH-1:0]       s4_t_in;
   logic [COORD_WIDTH-1:0]       s4_t_ff;

   // Stage 1: difference of point and centre
   always_comb begin
      s1_carry_in = '{point: in_point, origin: in_origin, dir: in_dir, ext: in_ext};
      for (int i = 0; i < 3; i++) begin
         s1_diff_in[i] = $signed({in_point[i][COORD_WIDTH-1], in_point[i]})
                       - $signed({in_origin[i][COORD_WIDTH-1], in_origin[i]});
      end
   end

   // Stage 2: exact products of direction and difference
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_prod_in[i] = $signed(s1_carry_ff.dir[i]) * s1_diff_ff[i];
      end
   end

   // Stage 3: exact dot product
   assign s3_sum_in = s2_prod_ff[0] + s2_prod_ff[1] + s2_prod_ff[2];

   // Stage 4: floor shift and clamp to the half length
   always_comb begin
      s4_shift   = $signed(s3_sum_ff[DOT_SUM_W-1:FRAC_BITS]);
      s4_ext     = $signed({{(SHIFT_W-EXT_W){1'b0}}, s3_carry_ff.ext});
      s4_neg_ext = -s4_ext;
      if (s4_shift > s4_ext) begin
         s4_t_in = s4_ext[COORD_WIDTH-1:0];
      end else if (s4_shift < s4_neg_ext) begin
         s4_t_in = s4_neg_ext[COORD_WIDTH-1:0];
      end else begin
         s4_t_in = s4_shift[COORD_WIDTH-1:0];
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // Advance the data words
   always_ff @(posedge clock) begin
      s1_carry_ff <= s1_carry_in;
      s2_carry_ff <= s1_carry_ff;
      s3_carry_ff <= s2_carry_ff;
      s4_carry_ff <= s3_carry_ff;
      s1_diff_ff  <= s1_diff_in;
      s2_prod_ff  <= s2_prod_in;
      s3_sum_ff   <= s3_sum_in;
      s4_t_ff     <= s4_t_in;
   end

   assign out = '{valid: s4_valid_ff, seg_param: s4_t_ff, point: s4_carry_ff.point,
                  origin: s4_carry_ff.origin, dir: s4_carry_ff.dir};

endmodule

`default_nettype wire

FILE: sv/psd_point.sv
`timescale 1ns / 1ps
`default_nettype none

module psd_point (
   input  logic               clock,
   input  logic               reset,
   input  psd_pkg::proj_type  in,
   output psd_pkg::dist_type  out
);
   import psd_pkg::*;

   logic                    s5_valid_ff, s6_valid_ff, s7_valid_ff, s8_valid_ff, s9_valid_ff;
   logic [COORD_WIDTH-1:0]  s5_t_ff, s6_t_ff, s7_t_ff, s8_t_ff, s9_t_ff;
   vec_type                 s5_point_ff, s6_point_ff;
   vec_type                 s5_origin_ff;
   vec_type                 s7_closest_in, s7_closest_ff, s8_closest_ff, s9_closest_ff;
   logic signed [TD_W-1:0]  s5_td_in [3];
   logic signed [TD_W-1:0]  s5_td_ff [3];
   logic signed [C_W-1:0]   s6_c_in [3];
   logic signed [C_W-1:0]   s6_c_ff [3];
   logic signed [DC_W-1:0]  s7_dc [3];
   logic [DC_W-1:0]         s7_mag [3];
   logic [SQ_W-1:0]         s7_mag_in [3];
   logic [SQ_W-1:0]         s7_mag_ff [3];
   logic [2:0]              s7_over_in, s7_over_ff, s8_over_ff;
   logic [DSQ_W-1:0]        s8_sq_in [3];
   logic [DSQ_W-1:0]        s8_sq_ff [3];
   logic [DSQ_W+1:0]        s9_sum;
   logic [DSQ_W-1:0]        s9_dsq_in;
   logic [DSQ_W-1:0]        s9_dsq_ff;

   // Stage 5: parameter times direction
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s5_td_in[i] = $signed(in.seg_param) * $signed(in.dir[i]);
      end
   end

   // Stage 6: closest point, exact, with floor shift
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s6_c_in[i] = $signed(s5_origin_ff[i]) + $signed(s5_td_ff[i][TD_W-1:FRAC_BITS]);
      end
   end

   // Stage 7: offset magnitude and saturated closest point
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s7_dc[i]      = s6_c_ff[i] - $signed(s6_point_ff[i]);
         s7_mag[i]     = s7_dc[i][DC_W-1] ? -s7_dc[i] : s7_dc[i];
         s7_over_in[i] = |s7_mag[i][DC_W-1:SQ_W];
         s7_mag_in[i]  = s7_mag[i][SQ_W-1:0];
         if ((&s6_c_ff[i][C_W-1:COORD_WIDTH-1]) || !(|s6_c_ff[i][C_W-1:COORD_WIDTH-1])) begin
            s7_closest_in[i] = s6_c_ff[i][COORD_WIDTH-1:0];
         end else if (s6_c_ff[i][C_W-1]) begin
            s7_closest_in[i] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
         end else begin
            s7_closest_in[i] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
         end
      end
   end

   // Stage 8: squares of the offsets
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s8_sq_in[i] = s7_mag_ff[i] * s7_mag_ff[i];
      end
   end

   // Stage 9: sum with saturation
   always_comb begin
      s9_sum = {2'b00, s8_sq_ff[0]} + {2'b00, s8_sq_ff[1]} + {2'b00, s8_sq_ff[2]};
      if ((|s8_over_ff) || (|s9_sum[DSQ_W+1:DSQ_W])) begin
         s9_dsq_in = '1;
      end else begin
         s9_dsq_in = s9_sum[DSQ_W-1:0];
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
         s8_valid_ff <= 1'b0;
         s9_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= in.valid;
         s6_valid_ff <= s5_valid_ff;
         s7_valid_ff <= s6_valid_ff;
         s8_valid_ff <= s7_valid_ff;
         s9_valid_ff <= s8_valid_ff;
      end
   end

   // Advance the data words
   always_ff @(posedge clock) begin
      s5_t_ff       <= in.seg_param;
      s6_t_ff       <= s5_t_ff;
      s7_t_ff       <= s6_t_ff;
      s8_t_ff       <= s7_t_ff;
      s9_t_ff       <= s8_t_ff;
      s5_point_ff   <= in.point;
      s6_point_ff   <= s5_point_ff;
      s5_origin_ff  <= in.origin;
      s5_td_ff      <= s5_td_in;
      s6_c_ff       <= s6_c_in;
      s7_mag_ff     <= s7_mag_in;
      s7_over_ff    <= s7_over_in;
      s8_over_ff    <= s7_over_ff;
      s7_closest_ff <= s7_closest_in;
      s8_closest_ff <= s7_closest_ff;
      s9_closest_ff <= s8_closest_ff;
      s8_sq_ff      <= s8_sq_in;
      s9_dsq_ff     <= s9_dsq_in;
   end

   assign out = '{valid: s9_valid_ff, seg_param: s9_t_ff, closest: s9_closest_ff,
                  dist_squared: s9_dsq_ff};

endmodule

`default_nettype wire

FILE: sv/psd_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module psd_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  psd_pkg::dist_type            in,
   output psd_pkg::dist_type            out,
   output logic [psd_pkg::DIST_W-1:0]   root
);
   import psd_pkg::*;

   dist_type           stage_ff [SQRT_STAGES];
   logic [DSQ_W-1:0]   x_in     [SQRT_STAGES];
   logic [DSQ_W-1:0]   x_ff     [SQRT_STAGES];
   logic [REM_W-1:0]   rem_in   [SQRT_STAGES];
   logic [REM_W-1:0]   rem_ff   [SQRT_STAGES];
   logic [DIST_W-1:0]  root_in  [SQRT_STAGES];
   logic [DIST_W-1:0]  root_ff  [SQRT_STAGES];

   // Two digits of the root in every stage
   always_comb begin
      logic [REM_W-1:0]  rem;
      logic [DSQ_W-1:0]  x;
      logic [DIST_W-1:0] rt;
      logic [REM_W-1:0]  trial;
      for (int s = 0; s < SQRT_STAGES; s++) begin
         if (s == 0) begin
            rem = '0;
            x   = in.dist_squared;
            rt  = '0;
         end else begin
            rem = rem_ff[s-1];
            x   = x_ff[s-1];
            rt  = root_ff[s-1];
         end
         for (int k = 0; k < SQRT_STEPS; k++) begin
            rem   = {rem[REM_W-3:0], x[DSQ_W-1:DSQ_W-2]};
            x     = {x[DSQ_W-3:0], 2'b00};
            rt    = {rt[DIST_W-2:0], 1'b0};
            trial = {{(REM_W-DIST_W-1){1'b0}}, rt, 1'b1};
            if (rem >= trial) begin
               rem   = rem - trial;
               rt[0] = 1'b1;
            end
         end
         rem_in[s]  = rem;
         x_in[s]    = x;
         root_in[s] = rt;
      end
   end

   // Advance valid bits and the data words together
   always_ff @(posedge clock) begin
      for (int s = 0; s < SQRT_STAGES; s++) begin
         if (reset) begin
            stage_ff[s].valid <= 1'b0;
         end else if (s == 0) begin
            stage_ff[s] <= in;
         end else begin
            stage_ff[s] <= stage_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      x_ff    <= x_in;
      root_ff <= root_in;
   end

   assign out  = stage_ff[SQRT_STAGES-1];
   assign root = root_ff[SQRT_STAGES-1];

endmodule

`default_nettype wire

FILE: sv/point_segment_distance_3d_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Point to segment distance in 3D, signed Q16.16 geometry.
// Request channel: drive the point, segment centre, unit direction and
// half length on the req_ ports and raise start; the word is taken at a
// rising edge where start is high and busy is low. busy stays low, so a
// new word may be taken at every clock edge.
// Response channel: rsp_valid is high for one cycle per request with the
// clamped parameter, the saturated closest point, the squared distance
// (Q32.32, all ones on overflow) and its floor square root (Q16.16).
// Throughput is one request per cycle. A request passes through 25
// register stages: four for the projection and clamp, five for the
// closest point and squared distance, sixteen for the square root, two
// digits per stage.
// Responses leave in request order. The receiver cannot stall, so a
// response is simply presented for its single cycle.
// Reset: synchronous; it clears all valid bits, so every request in
// flight is dropped and no response follows it.
module point_segment_distance_3d_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [psd_pkg::COORD_WIDTH-1:0] req_point_x,
   input  logic signed [psd_pkg::COORD_WIDTH-1:0] req_point_y,
   input  logic signed [psd_pkg::COORD_WIDTH-1:0] req_point_z,
   input  logic signed [psd_pkg::COORD_WIDTH-1:0] req_origin_x,
   input  logic signed [psd_pkg::COORD_WIDTH-1:0] req_origin_y,
   input  logic signed [psd_pkg::COORD_WIDTH-1:0] req_origin_z,
   input  logic signed [psd_pkg::COORD_WIDTH-1:0] req_dir_x,
   input  logic signed [psd_pkg::COORD_WIDTH-1:0] req_dir_y,
   input  logic signed [psd_pkg::COORD_WIDTH-1:0] req_dir_z,
   input  logic        [psd_pkg::EXT_W-1:0]       req_half_length,
   output logic                                  rsp_valid,
   output logic signed [psd_pkg::COORD_WIDTH-1:0] rsp_seg_param,
   output logic signed [psd_pkg::COORD_WIDTH-1:0] rsp_closest_x,
   output logic signed [psd_pkg::COORD_WIDTH-1:0] rsp_closest_y,
   output logic signed [psd_pkg::COORD_WIDTH-1:0] rsp_closest_z,
   output logic        [psd_pkg::DSQ_W-1:0]       rsp_dist_squared,
   output logic        [psd_pkg::DIST_W-1:0]      rsp_distance
);
   import psd_pkg::*;

   logic              accept;
   vec_type           req_point, req_origin, req_dir;
   proj_type          proj;
   dist_type          dist_word;
   dist_type          result;
   logic [DIST_W-1:0] root;

   // The pipeline never holds, so requests are always taken
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Gather the components
   assign req_point  = {req_point_z, req_point_y, req_point_x};
   assign req_origin = {req_origin_z, req_origin_y, req_origin_x};
   assign req_dir    = {req_dir_z, req_dir_y, req_dir_x};

   psd_proj u_proj (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_point  (req_point),
      .in_origin (req_origin),
      .in_dir    (req_dir),
      .in_ext    (req_half_length),
      .out       (proj)
   );

   psd_point u_point (
      .clock (clock),
      .reset (reset),
      .in    (proj),
      .out   (dist_word)
   );

   psd_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .in    (dist_word),
      .out   (result),
      .root  (root)
   );

   // Drive the response word
   assign rsp_valid        = result.valid;
   assign rsp_seg_param    = $signed(result.seg_param);
   assign rsp_closest_x    = $signed(result.closest[0]);
   assign rsp_closest_y    = $signed(result.closest[1]);
   assign rsp_closest_z    = $signed(result.closest[2]);
   assign rsp_dist_squared = result.dist_squared;
   assign rsp_distance     = root;

endmodule

`default_nettype wire

FILE: sv/psd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module psd_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  start,
   input logic                                  busy,
   input logic signed [psd_pkg::COORD_WIDTH-1:0] req_origin_x,
   input logic        [psd_pkg::EXT_W-1:0]       req_half_length,
   input logic                                  rsp_valid,
   input logic signed [psd_pkg::COORD_WIDTH-1:0] rsp_seg_param,
   input logic signed [psd_pkg::COORD_WIDTH-1:0] rsp_closest_x
);
   import psd_pkg::*;

   // Every response word traces back to a request a fixed latency earlier
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("response without a matching request");

   // Clamped parameter stays within the half length of its request
   a_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ($signed({rsp_seg_param[COORD_WIDTH-1], rsp_seg_param})
             <= $signed({2'b00, $past(req_half_length, LATENCY)}))
         && ($signed({rsp_seg_param[COORD_WIDTH-1], rsp_seg_param})
             >= -$signed({2'b00, $past(req_half_length, LATENCY)})))
      else $error("segment parameter outside the half length");

   // Zero half length puts the closest point on the centre
   a_zero_ext: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_half_length == '0, LATENCY)) |->
         (rsp_seg_param == '0) && (rsp_closest_x == $past(req_origin_x, LATENCY)))
      else $error("zero half length did not yield the centre");

endmodule

bind point_segment_distance_3d_unit psd_checker u_checker (.*);

`default_nettype wire
